### rtl/unv_pkg.sv
// Shared types and constants for the UTF-8 name validator.
// Used by unv_decode and utf8_name_validator_top; depends on nothing.

package unv_pkg;

   // Default length limit of a name in bytes
   localparam int MAX_NAME_BYTES_DEF = 64;

   // Lead byte ranges and masks
   localparam logic [7:0] CTRL_LIMIT   = 8'h20;
   localparam logic [7:0] DEL_CHAR     = 8'h7f;
   localparam logic [7:0] ASCII_LIMIT  = 8'h80;
   localparam logic [7:0] LEAD2_MASK   = 8'he0;
   localparam logic [7:0] LEAD2_CODE   = 8'hc0;
   localparam logic [7:0] LEAD3_MASK   = 8'hf0;
   localparam logic [7:0] LEAD3_CODE   = 8'he0;
   localparam logic [7:0] LEAD4_MASK   = 8'hf8;
   localparam logic [7:0] LEAD4_CODE   = 8'hf0;
   localparam logic [7:0] CONT_MASK    = 8'hc0;
   localparam logic [7:0] CONT_CODE    = 8'h80;

   // Code point limits
   localparam logic [20:0] MIN_CP_2B     = 21'h00080;
   localparam logic [20:0] MIN_CP_3B     = 21'h00800;
   localparam logic [20:0] MIN_CP_4B     = 21'h10000;
   localparam logic [20:0] MAX_CP        = 21'h10ffff;
   localparam logic [20:0] SURR_LOW      = 21'h0d800;
   localparam logic [20:0] SURR_HIGH     = 21'h0dfff;

   // Continuation bytes that a lead byte announces
   localparam logic [1:0] SEQ_NONE = 2'd0;
   localparam logic [1:0] SEQ_2B   = 2'd1;
   localparam logic [1:0] SEQ_3B   = 2'd2;
   localparam logic [1:0] SEQ_4B   = 2'd3;

   typedef struct packed {
      logic [1:0]  pending_count;
      logic [20:0] code_point;
      logic [1:0]  sequence_length;
      logic        error_seen;
   } dec_state_type;

endpackage

### rtl/unv_decode.sv
// Next-state logic of the UTF-8 decoder for one byte.
// Depends on unv_pkg for the state type and constants.

module unv_decode (
   input  unv_pkg::dec_state_type state,
   input  logic [7:0]             byte_value,
   input  logic                   last_byte,
   output unv_pkg::dec_state_type state_next,
   output logic                   error_out
);

   always_comb begin
      unv_pkg::dec_state_type s;
      logic [20:0]            cp;
      logic [1:0]             pend;
      s = state;
      cp = {state.code_point[14:0], byte_value[5:0]};
      pend = state.pending_count - 2'd1;
      if (state.pending_count == 2'd0) begin
         priority if (byte_value < unv_pkg::CTRL_LIMIT || byte_value == unv_pkg::DEL_CHAR) begin
            s.error_seen = 1'b1;
         end else if (byte_value < unv_pkg::ASCII_LIMIT) begin
            s = state;
         end else if ((byte_value & unv_pkg::LEAD2_MASK) == unv_pkg::LEAD2_CODE) begin
            s.pending_count   = unv_pkg::SEQ_2B;
            s.sequence_length = unv_pkg::SEQ_2B;
            s.code_point      = {16'd0, byte_value[4:0]};
         end else if ((byte_value & unv_pkg::LEAD3_MASK) == unv_pkg::LEAD3_CODE) begin
            s.pending_count   = unv_pkg::SEQ_3B;
            s.sequence_length = unv_pkg::SEQ_3B;
            s.code_point      = {17'd0, byte_value[3:0]};
         end else if ((byte_value & unv_pkg::LEAD4_MASK) == unv_pkg::LEAD4_CODE) begin
            s.pending_count   = unv_pkg::SEQ_4B;
            s.sequence_length = unv_pkg::SEQ_4B;
            s.code_point      = {18'd0, byte_value[2:0]};
         end else begin
            s.error_seen = 1'b1;
         end
      end else if ((byte_value & unv_pkg::CONT_MASK) != unv_pkg::CONT_CODE) begin
         // malformed continuation: drop the sequence
         s.error_seen    = 1'b1;
         s.pending_count = 2'd0;
      end else begin
         s.code_point    = cp;
         s.pending_count = pend;
         if (pend == 2'd0) begin
            if ((state.sequence_length == unv_pkg::SEQ_2B && cp < unv_pkg::MIN_CP_2B) ||
                (state.sequence_length == unv_pkg::SEQ_3B && cp < unv_pkg::MIN_CP_3B) ||
                (state.sequence_length == unv_pkg::SEQ_4B && cp < unv_pkg::MIN_CP_4B) ||
                cp > unv_pkg::MAX_CP ||
                (cp >= unv_pkg::SURR_LOW && cp <= unv_pkg::SURR_HIGH)) begin
               s.error_seen = 1'b1;
            end
         end
      end
      // truncated sequence at the end of the name
      if (last_byte && s.pending_count != 2'd0) begin
         s.error_seen = 1'b1;
      end
      error_out  = s.error_seen;
      state_next = last_byte ? '0 : s;
   end

endmodule

### rtl/utf8_name_validator_top.sv
// UTF-8 name validator: takes one byte per cycle while req_ready is high and gives one verdict per name.
// Latency: the verdict is valid in the cycle after the last byte's transaction.
// Throughput: one byte per cycle while req_ready is high; the decoder state is one register stage deep.
// req_ready drops only while a verdict waits in the output register unaccepted.
// Synchronous active-high reset clears decoder state, byte count and rsp_valid.
// Depends on unv_pkg and unv_decode.

module utf8_name_validator_top #(
   parameter int MAX_NAME_BYTES = unv_pkg::MAX_NAME_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_byte_value,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_name_valid
);

   localparam int CW = $clog2(MAX_NAME_BYTES + 2);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_NAME_BYTES);

   unv_pkg::dec_state_type state_ff, state_in, dec_next;
   logic [CW-1:0] byte_count_ff, byte_count_in, count_step;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          name_valid_ff, name_valid_in;
   logic          dec_error;
   logic          req_take;

   unv_decode u_decode (
      .state      (state_ff),
      .byte_value (req_byte_value),
      .last_byte  (req_last_byte),
      .state_next (dec_next),
      .error_out  (dec_error)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;

   // saturate one past the limit
   assign count_step = (byte_count_ff <= MAX_CNT) ? byte_count_ff + CW'(1) : byte_count_ff;

   always_comb begin
      state_in      = state_ff;
      byte_count_in = byte_count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      name_valid_in = name_valid_ff;
      if (req_take) begin
         state_in      = dec_next;
         byte_count_in = req_last_byte ? '0 : count_step;
         if (req_last_byte) begin
            rsp_valid_in  = 1'b1;
            name_valid_in = !dec_error && count_step <= MAX_CNT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= '0;
         byte_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         byte_count_ff <= byte_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      name_valid_ff <= name_valid_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_name_valid = name_valid_ff;

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      req_take && req_last_byte |=> state_ff == '0 && byte_count_ff == '0)
      else $error("state not cleared after end of name");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      byte_count_ff <= MAX_CNT + CW'(1))
      else $error("byte count beyond saturation");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(req_take && req_last_byte))
      else $error("verdict without end of name");

   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff.pending_count != 2'd0 |-> state_ff.pending_count <= state_ff.sequence_length)
      else $error("pending count exceeds sequence length");

endmodule

### test/utf8_name_validator_top_test.sv
`timescale 1ns / 1ps
// Testbench for utf8_name_validator_top: names go in byte by byte, verdicts are scored.
// Depends on unv_pkg and utf8_name_validator_top; carries its own decoder model.

module utf8_name_validator_top_test;

   localparam int NAME_LIMIT  = unv_pkg::MAX_NAME_BYTES_DEF;
   localparam int ITEM_TARGET = 1350;
   localparam int IDLE_LIMIT  = 2000;

   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } name_byte_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_byte_value = 8'h00;
   logic       req_last_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_name_valid;

   name_byte_type          byte_stream[$];
   logic [7:0]             name_buf[$];
   logic                   verdict_queue[$];
   unv_pkg::dec_state_type decode_st = '0;
   logic [6:0]             name_len = '0;
   logic                   req_taken = 1'b0;
   int                     mismatch_count = 0;
   int                     idle_cycles = 0;
   int                     burst_left = 1;
   int                     gap_left = 0;
   logic [15:0]            stall_pat = 16'hffff;
   logic [5:0]             stall_step = '0;

   utf8_name_validator_top #(.MAX_NAME_BYTES(NAME_LIMIT)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_byte_value (req_byte_value),
      .req_last_byte  (req_last_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_name_valid (rsp_name_valid)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Decode one byte; returns 1 when the byte closes a name and sets the verdict.
   function automatic bit name_step(input logic [7:0] b, input logic last,
                                    output logic verdict);
      logic [20:0] cp;
      verdict = 1'b0;
      if (name_len <= NAME_LIMIT) name_len = name_len + 7'd1;
      if (decode_st.pending_count == unv_pkg::SEQ_NONE) begin
         if (b < unv_pkg::CTRL_LIMIT || b == unv_pkg::DEL_CHAR) begin
            decode_st.error_seen = 1'b1;
         end else if (b < unv_pkg::ASCII_LIMIT) begin
         end else if ((b & unv_pkg::LEAD2_MASK) == unv_pkg::LEAD2_CODE) begin
            decode_st.pending_count = unv_pkg::SEQ_2B;
            decode_st.sequence_length = unv_pkg::SEQ_2B;
            decode_st.code_point = {16'd0, b[4:0]};
         end else if ((b & unv_pkg::LEAD3_MASK) == unv_pkg::LEAD3_CODE) begin
            decode_st.pending_count = unv_pkg::SEQ_3B;
            decode_st.sequence_length = unv_pkg::SEQ_3B;
            decode_st.code_point = {17'd0, b[3:0]};
         end else if ((b & unv_pkg::LEAD4_MASK) == unv_pkg::LEAD4_CODE) begin
            decode_st.pending_count = unv_pkg::SEQ_4B;
            decode_st.sequence_length = unv_pkg::SEQ_4B;
            decode_st.code_point = {18'd0, b[2:0]};
         end else begin
            decode_st.error_seen = 1'b1;
         end
      end else if ((b & unv_pkg::CONT_MASK) != unv_pkg::CONT_CODE) begin
         decode_st.error_seen = 1'b1;
         decode_st.pending_count = unv_pkg::SEQ_NONE;
      end else begin
         decode_st.code_point = {decode_st.code_point[14:0], b[5:0]};
         decode_st.pending_count = decode_st.pending_count - 2'd1;
         cp = decode_st.code_point;
         if (decode_st.pending_count == unv_pkg::SEQ_NONE &&
             ((decode_st.sequence_length == unv_pkg::SEQ_2B && cp < unv_pkg::MIN_CP_2B) ||
              (decode_st.sequence_length == unv_pkg::SEQ_3B && cp < unv_pkg::MIN_CP_3B) ||
              (decode_st.sequence_length == unv_pkg::SEQ_4B && cp < unv_pkg::MIN_CP_4B) ||
              cp > unv_pkg::MAX_CP ||
              (cp >= unv_pkg::SURR_LOW && cp <= unv_pkg::SURR_HIGH)))
            decode_st.error_seen = 1'b1;
      end
      if (!last) return 1'b0;
      // a name that stops inside a sequence is truncated
      if (decode_st.pending_count != unv_pkg::SEQ_NONE) decode_st.error_seen = 1'b1;
      verdict = !decode_st.error_seen && name_len <= NAME_LIMIT;
      decode_st = '0;
      name_len = '0;
      return 1'b1;
   endfunction

   // Append one byte to the name being built
   task automatic add_byte(input logic [7:0] b);
      name_buf = {name_buf, b};
   endtask

   // Encode a code point in nb bytes; widths larger than needed give overlong forms on purpose.
   task automatic put_utf8(input logic [20:0] cp, input int nb);
      case (nb)
         1: add_byte(cp[7:0]);
         2: begin
            add_byte({3'b110, cp[10:6]});
            add_byte({2'b10, cp[5:0]});
         end
         3: begin
            add_byte({4'b1110, cp[15:12]});
            add_byte({2'b10, cp[11:6]});
            add_byte({2'b10, cp[5:0]});
         end
         default: begin
            add_byte({5'b11110, cp[20:18]});
            add_byte({2'b10, cp[17:12]});
            add_byte({2'b10, cp[11:6]});
            add_byte({2'b10, cp[5:0]});
         end
      endcase
   endtask

   // Lead byte plus too few continuations; end with a non-continuation unless cut.
   task automatic put_broken(input bit cut);
      int         nb;
      int         conts;
      logic [7:0] b;
      nb = $urandom_range(2, 4);
      b = 8'($urandom_range(0, 255));
      case (nb)
         2: add_byte({3'b110, b[4:0]});
         3: add_byte({4'b1110, b[3:0]});
         default: add_byte({5'b11110, b[2:0]});
      endcase
      conts = $urandom_range(0, nb - 2);
      for (int i = 0; i < conts; i++) begin
         b = 8'($urandom_range(0, 255));
         add_byte({2'b10, b[5:0]});
      end
      if (!cut) begin
         b = 8'($urandom_range(0, 255));
         if (b[7:6] == 2'b10) b[6] = 1'b1;
         add_byte(b);
      end
   endtask

   task automatic put_random_char(input bit faulty);
      int          kind;
      logic [20:0] cp;
      kind = $urandom_range(0, faulty ? 99 : 79);
      if (kind < 40) begin
         put_utf8(21'($urandom_range(21'h20, 21'h7e)), 1);
      end else if (kind < 52) begin
         put_utf8(21'($urandom_range(21'h80, 21'h7ff)), 2);
      end else if (kind < 66) begin
         cp = ($urandom_range(0, 1) == 0) ? 21'($urandom_range(21'h800, 21'hd7ff))
                                          : 21'($urandom_range(21'he000, 21'hffff));
         put_utf8(cp, 3);
      end else if (kind < 80) begin
         put_utf8(21'($urandom_range(21'h10000, 21'h10ffff)), 4);
      end else begin
         case (kind - 80)
            0, 1:   add_byte(8'($urandom_range(0, 8'h1f)));
            2:      add_byte(unv_pkg::DEL_CHAR);
            3, 4:   add_byte(8'($urandom_range(8'h80, 8'hbf)));
            5, 6:   add_byte(8'($urandom_range(8'hf8, 8'hff)));
            7:      put_utf8(21'($urandom_range(0, 21'h7f)), 2);
            8:      put_utf8(21'($urandom_range(0, 21'h7ff)), 3);
            9:      put_utf8(21'($urandom_range(0, 21'hffff)), 4);
            10, 11: put_utf8(21'($urandom_range(unv_pkg::SURR_LOW, unv_pkg::SURR_HIGH)), 3);
            12:     put_utf8(21'($urandom_range(21'h110000, 21'h1fffff)), 4);
            13, 14: put_broken(1'b0);
            default: add_byte(8'($urandom_range(0, 255)));
         endcase
      end
   endtask

   task automatic close_name();
      name_byte_type nb;
      foreach (name_buf[i]) begin
         nb.value = name_buf[i];
         nb.last = (i == name_buf.size() - 1);
         byte_stream = {byte_stream, nb};
      end
      name_buf.delete();
   endtask

   // Up to four bytes packed most significant first
   task automatic directed_name(input logic [31:0] word, input int n);
      for (int i = n - 1; i >= 0; i--) add_byte(word[8*i +: 8]);
      close_name();
   endtask

   initial begin
      int pick;
      int target;
      bit faulty;

      directed_name(32'h20, 1);
      directed_name(32'h7e, 1);
      directed_name(32'h00, 1);
      directed_name(32'h1f, 1);
      directed_name(32'h7f, 1);
      directed_name(32'h80, 1);
      directed_name(32'hbf, 1);
      directed_name(32'hf8, 1);
      directed_name(32'hff, 1);
      directed_name(32'hc280, 2);
      directed_name(32'hc1bf, 2);       // overlong two-byte form
      directed_name(32'he09fbf, 3);     // overlong three-byte form
      directed_name(32'heda080, 3);     // surrogate
      directed_name(32'hf48fbfbf, 4);   // highest code point
      directed_name(32'hf4908080, 4);   // past the top of the range
      directed_name(32'hf08fbfbf, 4);   // overlong four-byte form
      directed_name(32'hc3, 1);         // cut off mid sequence
      directed_name(32'hc341, 2);       // bad continuation
      directed_name(32'h0141, 2);       // error stays set over a good byte

      while (byte_stream.size() < ITEM_TARGET) begin
         faulty = ($urandom_range(0, 99) < 30);
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            target = $urandom_range(100, 140);
         end else if (pick < 7) begin
            // plain names right around the length limit
            target = $urandom_range(NAME_LIMIT - 1, NAME_LIMIT + 2);
            for (int i = 0; i < target; i++)
               put_utf8(21'($urandom_range(21'h20, 21'h7e)), 1);
         end else if (pick < 11) begin
            target = $urandom_range(NAME_LIMIT - 6, NAME_LIMIT + 8);
         end else begin
            target = $urandom_range(1, 12);
         end
         while (name_buf.size() < target) put_random_char(faulty);
         if (faulty && $urandom_range(0, 9) == 0) put_broken(1'b1);
         close_name();
      end

      repeat (9) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (byte_stream.size() != 0 || req_valid || verdict_queue.size() != 0)
         @(negedge clock);
      repeat (10) @(negedge clock);
      if (verdict_queue.size() != 0)
         $display("%0d verdicts never arrived", verdict_queue.size());
      if (mismatch_count == 0 && verdict_queue.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Sender: bursts of random length, random gaps, some with no gap at all
   always @(negedge clock) begin : byte_driver
      name_byte_type nb;
      logic          next_valid;
      next_valid = req_valid;
      if (reset) begin
         next_valid = 1'b0;
      end else if (!req_valid || req_taken) begin
         next_valid = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (byte_stream.size() != 0) begin
            nb = byte_stream.pop_front();
            req_byte_value <= nb.value;
            req_last_byte <= nb.last;
            next_valid = 1'b1;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
      end
      req_valid <= next_valid;
   end

   // Receiver: rotate a 16-bit ready pattern, pick a fresh one each time the 6-bit step counter wraps
   always @(negedge clock) begin : verdict_stall
      if (stall_step == 6'd0) begin
         case ($urandom_range(0, 3))
            0: stall_pat = 16'hffff;
            1: stall_pat = 16'($urandom_range(0, 16'hffff)) | 16'h0001;
            2: stall_pat = (16'($urandom_range(0, 16'hffff)) & 16'($urandom_range(0, 16'hffff)))
                           | 16'h0001;
            default: stall_pat = 16'($urandom_range(0, 16'hffff))
                                 | 16'($urandom_range(0, 16'hffff)) | 16'h0001;
         endcase
      end
      rsp_ready <= stall_pat[stall_step[3:0]];
      stall_step = stall_step + 6'd1;
   end

   always @(posedge clock) begin : verdict_monitor
      logic verdict;
      logic want;
      if (reset) begin
         req_taken <= 1'b0;
         idle_cycles = 0;
      end else begin
         req_taken <= req_valid && req_ready;
         // score the outgoing verdict before the incoming byte adds a new one
         if (rsp_valid && rsp_ready) begin
            if (verdict_queue.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%t: verdict %0b with no name pending", $realtime, rsp_name_valid);
            end else begin
               want = verdict_queue.pop_front();
               if (rsp_name_valid !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%t: name_valid expected %0b, got %0b", $realtime, want,
                              rsp_name_valid);
               end
            end
         end
         if (req_valid && req_ready && name_step(req_byte_value, req_last_byte, verdict))
            verdict_queue = {verdict_queue, verdict};
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
               $display("%t: no transaction for %0d cycles", $realtime, IDLE_LIMIT);
               $display("SCOREBOARD MISMATCH");
               $finish;
            end
         end
      end
   end

endmodule
